/* hdl/lpht_pkg.sv */
// Package for the linear probing hash table.
// Holds the table size, operation and status codes, payload structs and the sequencer states.
// No dependencies.
`default_nettype none

package lpht_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = $clog2(SLOTS);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  localparam logic [1:0] RES_OK        = 2'd0;
  localparam logic [1:0] RES_NOT_FOUND = 2'd1;
  localparam logic [1:0] RES_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [30:0]        key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] result_value;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

endpackage

`default_nettype wire

/* hdl/linear_probe_hash_table.sv */
// Top level of the linear probing hash table: sequencer, slot storage and result register.
// Depends on lpht_pkg.
//
//   channel   ports              handshake
//   request   start, busy, req   taken when start is high and busy is low
//   response  done, rsp          one transaction per request, valid for one cycle
//
// Each request probes one slot per cycle, starting at the home slot key mod SLOTS,
// so it probes from 1 to SLOTS slots; the response follows in the next cycle.
// The single slot read and compare path is the shared unit, so busy stays high
// until the response is issued. Reset clears all slot status to empty at once.
// The receiver cannot stall; a response is lost if not taken in its cycle.
`default_nettype none

module linear_probe_hash_table (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire lpht_pkg::req_t req,
  output logic               done,
  output lpht_pkg::rsp_t     rsp
);

  lpht_pkg::state_t state, state_next;
  lpht_pkg::req_t   req_q;
  logic [lpht_pkg::IDX_W-1:0] idx, idx_next;
  logic [lpht_pkg::IDX_W-1:0] count, count_next;

  logic [1:0]         slot_status [lpht_pkg::SLOTS];
  logic [30:0]        slot_key    [lpht_pkg::SLOTS];
  logic signed [31:0] slot_value  [lpht_pkg::SLOTS];

  logic               finish;
  lpht_pkg::rsp_t     rsp_next;
  logic               wr_en;
  logic               wr_kv;
  logic [1:0]         wr_status;
  logic signed [31:0] wr_value;

  logic [1:0]         cur_status;
  logic               last;
  logic               key_hit;
  logic [lpht_pkg::IDX_W-1:0] home;

  assign cur_status = slot_status[idx];
  assign key_hit    = (cur_status == lpht_pkg::SLOT_USED) && (slot_key[idx] == req_q.key);
  assign last       = (count == lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1));
  assign home       = lpht_pkg::IDX_W'(req.key % 31'(lpht_pkg::SLOTS));
  assign busy       = (state != lpht_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = (idx == lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1)) ? '0 : idx + 1'b1;
    count_next = count + 1'b1;
    finish     = 1'b0;
    rsp_next   = '{status: lpht_pkg::RES_OK, result_value: 32'sd0};
    wr_en      = 1'b0;
    wr_kv      = 1'b0;
    wr_status  = lpht_pkg::SLOT_USED;
    wr_value   = req_q.value;
    unique case (state)
      lpht_pkg::S_IDLE: begin
        idx_next   = home;
        count_next = '0;
        if (start) begin
          state_next = lpht_pkg::S_PROBE;
        end
      end
      lpht_pkg::S_PROBE: begin
        priority if (req_q.func == lpht_pkg::OP_INSERT) begin
          if (cur_status != lpht_pkg::SLOT_USED) begin
            finish    = 1'b1;
            wr_en     = 1'b1;
            wr_kv     = 1'b1;
          end else if (last) begin
            finish          = 1'b1;
            rsp_next.status = lpht_pkg::RES_FULL;
          end
        end else if (req_q.func == lpht_pkg::OP_SEARCH ||
                     req_q.func == lpht_pkg::OP_DELETE) begin
          if (cur_status == lpht_pkg::SLOT_EMPTY) begin
            finish          = 1'b1;
            rsp_next.status = lpht_pkg::RES_NOT_FOUND;
          end else if (key_hit) begin
            finish = 1'b1;
            if (req_q.func == lpht_pkg::OP_SEARCH) begin
              rsp_next.result_value = slot_value[idx];
            end else begin
              wr_en     = 1'b1;
              wr_status = lpht_pkg::SLOT_DELETED;
              wr_value  = 32'sd0;
            end
          end else if (last) begin
            finish          = 1'b1;
            rsp_next.status = lpht_pkg::RES_NOT_FOUND;
          end
        end else begin
          finish = 1'b1;
        end
        if (finish) begin
          state_next = lpht_pkg::S_IDLE;
        end
      end
      default: state_next = lpht_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    count <= count_next;
    if (state == lpht_pkg::S_IDLE && start) begin
      req_q <= req;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
        slot_status[i] <= lpht_pkg::SLOT_EMPTY;
      end
    end else if (wr_en) begin
      slot_status[idx] <= wr_status;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_value[idx] <= wr_value;
      if (wr_kv) begin
        slot_key[idx] <= req_q.key;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/lpht_checker.sv */
// Port-level checker for the linear probing hash table, bound to the top level.
// Depends on lpht_pkg and linear_probe_hash_table.
`default_nettype none

module lpht_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           start,
  input wire logic           busy,
  input wire lpht_pkg::req_t req,
  input wire logic           done,
  input wire lpht_pkg::rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("Response issued while still busy.");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("Busy dropped without a response.");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("Two responses in consecutive cycles.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == lpht_pkg::RES_OK) ||
             ((rsp.status == lpht_pkg::RES_NOT_FOUND || rsp.status == lpht_pkg::RES_FULL)
              && rsp.result_value == 32'sd0))
    else $error("Invalid status or nonzero value on a failed transaction.");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);

`default_nettype wire
